>>> hw/rtl/dsa_pkg.sv
// shared types, widths and codes of the descriptor slot allocator
package dsa_pkg;

   localparam int CAPACITY_DEF = 1024;

   localparam int INDEX_W   = 10;
   localparam int COUNT_W   = 11;
   localparam int LIMIT_W   = 11;
   localparam int BASE_W    = 48;
   localparam int STRIDE_W  = 13;
   localparam int ADDR_W    = 64;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 48;
   // wide enough for any count or limit compare up to twice the largest capacity
   localparam int CMP_W     = 18;

   localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 11'd1024;
   localparam logic [BASE_W-1:0]   BASE_RST   = 48'd0;
   localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd32;

   typedef enum logic [1:0] {
      ST_OK               = 2'd0,
      ST_OUT_OF_SLOTS     = 2'd1,
      ST_FREE_NONE_ACTIVE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOT_LIMIT   = 2'd0,
      CSR_BASE_ADDRESS = 2'd1,
      CSR_SLOT_STRIDE  = 2'd2
   } csr_reg_type;

   typedef enum logic [0:0] {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   // commands from the control into the free list
   typedef struct packed {
      logic               push;
      logic               pop;
      logic [INDEX_W-1:0] wdata;
   } fl_cmd_type;

   // free list status seen by the control
   typedef struct packed {
      logic               empty;
      logic               full;
      logic [INDEX_W-1:0] rdata;
   } fl_stat_type;

endpackage

>>> hw/rtl/dsa_free_list.sv
// fifo free list: slot index memory with head, tail and fill count
module dsa_free_list #(
   parameter int CAPACITY = dsa_pkg::CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dsa_pkg::fl_cmd_type            cmd,
   output dsa_pkg::fl_stat_type           stat,
   output logic [$clog2(CAPACITY+1)-1:0]  fill
);

   localparam int PW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_FILL = CW'(CAPACITY);

   logic [dsa_pkg::INDEX_W-1:0] mem_ff [CAPACITY];
   logic [dsa_pkg::INDEX_W-1:0] rdata_ff;
   logic [PW-1:0]               head_ff, head_in;
   logic [PW-1:0]               tail_ff, tail_in;
   logic [CW-1:0]               fill_ff, fill_in;

   // memory port: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem_ff[tail_ff] <= cmd.wdata;
      end
      rdata_ff <= mem_ff[head_ff];
   end

   // pointer and fill updates with wrap at the last entry
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (cmd.pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (cmd.push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      case ({cmd.push, cmd.pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   assign stat.empty = (fill_ff == '0);
   assign stat.full  = (fill_ff == FULL_FILL);
   assign stat.rdata = rdata_ff;
   assign fill       = fill_ff;

endmodule

>>> hw/rtl/dsa_addr_unit.sv
// address multiply-add and response output register
module dsa_addr_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic                           granted,
   input  logic [dsa_pkg::INDEX_W-1:0]    idx,
   input  dsa_pkg::status_type            status,
   input  logic [dsa_pkg::COUNT_W-1:0]    count,
   input  logic [dsa_pkg::BASE_W-1:0]     base,
   input  logic [dsa_pkg::STRIDE_W-1:0]   stride,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dsa_pkg::INDEX_W-1:0]    rsp_slot_index,
   output logic [dsa_pkg::ADDR_W-1:0]     rsp_slot_address,
   output logic [1:0]                     rsp_status,
   output logic [dsa_pkg::COUNT_W-1:0]    rsp_active_count
);

   localparam int PROD_W = dsa_pkg::INDEX_W + dsa_pkg::STRIDE_W;

   logic                          valid_ff;
   logic [dsa_pkg::INDEX_W-1:0]   index_ff;
   logic [dsa_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   dsa_pkg::status_type           status_ff;
   logic [dsa_pkg::COUNT_W-1:0]   count_ff;
   logic [PROD_W-1:0]             prod;

   // base plus index times stride, zero when nothing was granted
   always_comb begin
      prod    = PROD_W'(idx) * PROD_W'(stride);
      addr_in = granted ? dsa_pkg::ADDR_W'(base) + dsa_pkg::ADDR_W'(prod) : '0;
   end

   // response valid holds until the transaction is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff  <= granted ? idx : '0;
         addr_ff   <= addr_in;
         status_ff <= status;
         count_ff  <= count;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_slot_index   = index_ff;
   assign rsp_slot_address = addr_ff;
   assign rsp_status       = status_ff;
   assign rsp_active_count = count_ff;

endmodule

>>> hw/rtl/descriptor_slot_allocator.sv
// descriptor slot allocator top: csr, request control and counters
//
//  channel  direction  handshake          payload
//  req_     in         valid / stall      func, release_index
//  rsp_     out        valid / stall      slot_index, slot_address, status, active_count
//  csr_     in         valid / ready      index, data
//
// each request passes the idle, exec and addr states: accept with the free list
// head read, then the decision on the registered memory data and the
// read-modify-write of counters and free list, then the address multiply-add
// into the response register. the memory read and the multiply stage set this order.
// reset clears counters and pointers; the free list memory is not cleared.
// a stalled response holds its register; the next request is accepted while it
// waits and waits itself only in the addr state for the register to drain.
module descriptor_slot_allocator #(
   parameter int CAPACITY = dsa_pkg::CAPACITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_func,
   input  logic [dsa_pkg::INDEX_W-1:0]      req_release_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dsa_pkg::INDEX_W-1:0]      rsp_slot_index,
   output logic [dsa_pkg::ADDR_W-1:0]       rsp_slot_address,
   output logic [1:0]                       rsp_status,
   output logic [dsa_pkg::COUNT_W-1:0]      rsp_active_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dsa_pkg::CSR_DAT_W-1:0]    csr_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int CMP_W = dsa_pkg::CMP_W;
   localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_ADDR = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [dsa_pkg::LIMIT_W-1:0]      limit_ff;
   logic [dsa_pkg::BASE_W-1:0]       base_ff;
   logic [dsa_pkg::STRIDE_W-1:0]     stride_ff;
   logic [CW-1:0]                    fresh_ff, fresh_in;
   logic [CW-1:0]                    handles_ff, handles_in;
   logic                             func_ff;
   logic [dsa_pkg::INDEX_W-1:0]      rel_ff;
   logic [dsa_pkg::INDEX_W-1:0]      idx_ff, idx_in;
   logic                             granted_ff, granted_in;
   dsa_pkg::status_type              status_ff, status_in;
   dsa_pkg::fl_cmd_type              fl_cmd;
   dsa_pkg::fl_stat_type             fl_stat;
   logic [CW-1:0]                    fl_fill;
   logic [CMP_W-1:0]                 limit_cmp, limit_eff;
   logic                             fresh_ok;
   logic                             req_take;
   logic                             out_free;
   logic                             out_load;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= dsa_pkg::LIMIT_RST;
         base_ff   <= dsa_pkg::BASE_RST;
         stride_ff <= dsa_pkg::STRIDE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dsa_pkg::CSR_SLOT_LIMIT:   limit_ff  <= csr_data[dsa_pkg::LIMIT_W-1:0];
            dsa_pkg::CSR_BASE_ADDRESS: base_ff   <= csr_data[dsa_pkg::BASE_W-1:0];
            dsa_pkg::CSR_SLOT_STRIDE:  stride_ff <= csr_data[dsa_pkg::STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // request intake
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid || !rsp_stall;
   assign out_load  = (state_ff == S_ADDR) && out_free;

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_func;
         rel_ff  <= req_release_index;
      end
   end

   // effective limit clipped to the built capacity
   always_comb begin
      limit_cmp = CMP_W'(limit_ff);
      limit_eff = (limit_cmp > CAP_CMP) ? CAP_CMP : limit_cmp;
      fresh_ok  = CMP_W'(fresh_ff) < limit_eff;
   end

   // decision on the registered free list head
   always_comb begin
      fresh_in     = fresh_ff;
      handles_in   = handles_ff;
      idx_in       = idx_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      fl_cmd.push  = 1'b0;
      fl_cmd.pop   = 1'b0;
      fl_cmd.wdata = rel_ff;
      if (state_ff == S_EXEC) begin
         idx_in     = '0;
         granted_in = 1'b0;
         status_in  = dsa_pkg::ST_OK;
         if (func_ff == dsa_pkg::FUNC_ALLOC) begin
            if (fresh_ok) begin
               idx_in     = dsa_pkg::INDEX_W'(fresh_ff);
               fresh_in   = fresh_ff + 1'b1;
               granted_in = 1'b1;
               handles_in = handles_ff + 1'b1;
            end else if (!fl_stat.empty) begin
               idx_in     = fl_stat.rdata;
               fl_cmd.pop = 1'b1;
               granted_in = 1'b1;
               handles_in = handles_ff + 1'b1;
            end else begin
               status_in = dsa_pkg::ST_OUT_OF_SLOTS;
            end
         end else begin
            if (handles_ff == '0) begin
               status_in = dsa_pkg::ST_FREE_NONE_ACTIVE;
            end else begin
               fl_cmd.push = !fl_stat.full;
               handles_in  = handles_ff - 1'b1;
            end
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_take) state_in = S_EXEC;
         S_EXEC:  state_in = S_ADDR;
         S_ADDR:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fresh_ff   <= '0;
         handles_ff <= '0;
      end else begin
         state_ff   <= state_in;
         fresh_ff   <= fresh_in;
         handles_ff <= handles_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
   end

   dsa_free_list #(
      .CAPACITY (CAPACITY)
   ) u_free_list (
      .clock (clock),
      .reset (reset),
      .cmd   (fl_cmd),
      .stat  (fl_stat),
      .fill  (fl_fill)
   );

   dsa_addr_unit u_addr_unit (
      .clock            (clock),
      .reset            (reset),
      .load             (out_load),
      .granted          (granted_ff),
      .idx              (idx_ff),
      .status           (status_ff),
      .count            (dsa_pkg::COUNT_W'(handles_ff)),
      .base             (base_ff),
      .stride           (stride_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_slot_address (rsp_slot_address),
      .rsp_status       (rsp_status),
      .rsp_active_count (rsp_active_count)
   );

   // free list entries plus handles out never exceed the capacity
   a_slots_conserved: assert property (@(posedge clock) disable iff (reset)
      (CMP_W'(fl_fill) + CMP_W'(handles_ff)) <= CAP_CMP)
      else $error("free list fill plus handles out exceeds capacity");

   // a push never meets a full free list
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      fl_cmd.push |-> !fl_stat.full)
      else $error("push onto a full free list");

   // a new response appears only from the address stage
   a_rsp_from_addr: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_ADDR))
      else $error("response raised outside the address stage");

   // fresh slots never pass the built capacity
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fresh_ff) <= CAP_CMP)
      else $error("bump counter beyond capacity");

endmodule
